FILE: hdl/slcfr_pkg.sv
// Shared constants and types of the sync/length/checksum frame receiver.
package slcfr_pkg;

   localparam logic [7:0] SYNC_RESET = 8'h55;

   // Frame type codes carried in the type byte.
   localparam logic [7:0] TYPE_END     = 8'h04;
   localparam logic [7:0] TYPE_BOARD   = 8'h06;
   localparam logic [7:0] TYPE_PLAYERS = 8'h07;
   localparam logic [7:0] TYPE_PING    = 8'h11;

   typedef enum logic [2:0] {
      CLASS_END     = 3'd0,
      CLASS_BOARD   = 3'd1,
      CLASS_PLAYERS = 3'd2,
      CLASS_PING    = 3'd3,
      CLASS_UNKNOWN = 3'd4
   } msg_class_type;

   function automatic msg_class_type class_of(input logic [7:0] frame_type);
      msg_class_type cls;
      case (frame_type)
         TYPE_END:     cls = CLASS_END;
         TYPE_BOARD:   cls = CLASS_BOARD;
         TYPE_PLAYERS: cls = CLASS_PLAYERS;
         TYPE_PING:    cls = CLASS_PING;
         default:      cls = CLASS_UNKNOWN;
      endcase
      return cls;
   endfunction

endpackage

FILE: hdl/slcfr_if.sv
// Valid/ready channel interfaces for received bytes and decoded results.
interface slcfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slcfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;
   logic [7:0] index;
   logic [7:0] raw_type;
   logic [2:0] msg_class;
   logic       checksum_ok;
   logic       last;

   modport source (output valid, output data, output index, output raw_type,
                   output msg_class, output checksum_ok, output last, input ready);
   modport sink   (input valid, input data, input index, input raw_type,
                   input msg_class, input checksum_ok, input last, output ready);
endinterface

FILE: hdl/sync_length_checksum_frame_receiver.sv
// Top level of the sync/length/type frame receiver with additive checksum.
//
// The receiver takes one stream byte per cycle as long as the result side keeps
// up: a byte is held in the input register, the frame parser decodes it
// against the current phase and any result lands in the output register. While
// a result waits in the output register under back-pressure, the held byte
// waits too and the input stalls, header and idle bytes included, until that
// result is taken.
// Bytes are dropped until one equals the sync register; then come a length
// byte, a type byte, that many payload bytes (each gives one item with its
// index) and a checksum byte, which gives a final item flagged last with the
// frame class and whether type plus payload, modulo 256, matched it. The sync
// register should be written only while the receiver is idle.
module sync_length_checksum_frame_receiver
   import slcfr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   slcfr_req_if.sink         req_ch,
   slcfr_rsp_if.source       rsp_ch,
   input  logic              csr_we,
   input  logic [7:0]        csr_wdata
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LENGTH,
      PH_TYPE,
      PH_PAYLOAD,
      PH_CHECK
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] sync_ff;
   logic [7:0] remaining_ff, remaining_in;
   logic [7:0] pidx_ff, pidx_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] ftype_ff, ftype_in;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   logic       rsp_valid_ff;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic [7:0] rsp_index_ff, rsp_index_in;
   logic [7:0] rsp_type_ff;
   logic [2:0] rsp_class_ff;
   logic       rsp_ok_ff, rsp_ok_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       emit;

   logic advance;

   // The held byte moves on once the output register is free or being drained.
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      pidx_in      = pidx_ff;
      sum_in       = sum_ff;
      ftype_in     = ftype_ff;
      emit         = 1'b0;
      rsp_data_in  = in_byte_ff;
      rsp_index_in = pidx_ff;
      rsp_ok_in    = 1'b0;
      rsp_last_in  = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (in_byte_ff == sync_ff) begin
               phase_in = PH_LENGTH;
            end
         end
         PH_LENGTH: begin
            remaining_in = in_byte_ff;
            pidx_in      = 8'd0;
            phase_in     = PH_TYPE;
         end
         PH_TYPE: begin
            ftype_in = in_byte_ff;
            sum_in   = in_byte_ff;
            phase_in = (remaining_ff == 8'd0) ? PH_CHECK : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            emit         = 1'b1;
            sum_in       = sum_ff + in_byte_ff;
            pidx_in      = pidx_ff + 8'd1;
            remaining_in = remaining_ff - 8'd1;
            if (remaining_ff == 8'd1) begin
               phase_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            emit         = 1'b1;
            rsp_data_in  = 8'd0;
            rsp_index_in = 8'd0;
            rsp_ok_in    = (sum_ff == in_byte_ff);
            rsp_last_in  = 1'b1;
            phase_in     = PH_IDLE;
            remaining_in = 8'd0;
            pidx_in      = 8'd0;
            sum_in       = 8'd0;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff      <= SYNC_RESET;
         phase_ff     <= PH_IDLE;
         remaining_ff <= 8'd0;
         pidx_ff      <= 8'd0;
         sum_ff       <= 8'd0;
         ftype_ff     <= 8'd0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            sync_ff <= csr_wdata;
         end
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            phase_ff     <= phase_in;
            remaining_ff <= remaining_in;
            pidx_ff      <= pidx_in;
            sum_ff       <= sum_in;
            ftype_ff     <= ftype_in;
         end
         if (advance && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers, no reset needed.
   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_byte_ff <= req_ch.rx_byte;
      end
      if (advance && emit) begin
         rsp_data_ff  <= rsp_data_in;
         rsp_index_ff <= rsp_index_in;
         rsp_type_ff  <= ftype_ff;
         rsp_class_ff <= class_of(ftype_ff);
         rsp_ok_ff    <= rsp_ok_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.data        = rsp_data_ff;
   assign rsp_ch.index       = rsp_index_ff;
   assign rsp_ch.raw_type    = rsp_type_ff;
   assign rsp_ch.msg_class   = rsp_class_ff;
   assign rsp_ch.checksum_ok = rsp_ok_ff;
   assign rsp_ch.last        = rsp_last_ff;

   // While payload is expected, at least one payload byte is still owed.
   a_payload_remaining: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> remaining_ff != 8'd0)
      else $error("payload phase with no bytes remaining");

   // A consumed payload byte always shows up as a result item.
   a_payload_emits: assert property (@(posedge clock) disable iff (reset)
      advance && phase_ff == PH_PAYLOAD |=> rsp_valid_ff && !rsp_last_ff)
      else $error("payload byte produced no result item");

   // The checksum byte closes the frame and yields the final item.
   a_check_closes: assert property (@(posedge clock) disable iff (reset)
      advance && phase_ff == PH_CHECK |=> phase_ff == PH_IDLE && rsp_valid_ff
         && rsp_last_ff && sum_ff == 8'd0)
      else $error("checksum byte did not close the frame");

   // Only the final item can carry a checksum verdict.
   a_ok_only_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> !rsp_ok_ff)
      else $error("checksum flag set on a payload item");

endmodule

FILE: dv/tb_sync_length_checksum_frame_receiver.sv
// Self-checking testbench for the sync/length/type frame receiver with additive checksum.
`timescale 1ns / 100ps

module tb_sync_length_checksum_frame_receiver;
   import slcfr_pkg::*;

   localparam int unsigned QUIET_LIMIT  = 2000;
   localparam int unsigned DRAIN_CYCLES = 6;
   localparam int unsigned PHASE_ITEMS  = 165;
   localparam int unsigned NUM_PHASES   = 8;

   // Idling mixes: none, sender idle, receiver stalling, both lightly.
   localparam int unsigned SEND_IDLE_PCT [4] = '{0, 67, 0, 8};
   localparam int unsigned STALL_PCT     [4] = '{0, 0, 67, 8};
   localparam logic [7:0]  SYNC_PLAN [NUM_PHASES] =
      '{8'h00, 8'hFF, 8'hA5, 8'h55, 8'h01, 8'h80, 8'h3C, 8'h55};

   typedef enum logic [2:0] {
      SEEK_SYNC,
      TAKE_LENGTH,
      TAKE_TYPE,
      TAKE_PAYLOAD,
      TAKE_CHECKSUM
   } rx_phase_type;

   typedef struct packed {
      logic [7:0]    data;
      logic [7:0]    index;
      logic [7:0]    raw_type;
      msg_class_type msg_class;
      logic          checksum_ok;
      logic          last;
   } frame_result_type;

   typedef struct packed {
      logic [7:0]       rx_byte;
      logic             typed;
      frame_result_type result;
   } stim_row_type;

   localparam frame_result_type NO_RESULT = '0;

   // Directed frames under the reset sync value. Only rows that produce an item
   // carry a typed-in expectation.
   localparam stim_row_type DIRECTED [25] = '{
      '{8'h00, 1'b0, NO_RESULT},        // idle bytes are dropped
      '{8'hFF, 1'b0, NO_RESULT},
      '{SYNC_RESET, 1'b0, NO_RESULT},   // zero-length end frame
      '{8'h00, 1'b0, NO_RESULT},
      '{TYPE_END, 1'b0, NO_RESULT},
      '{TYPE_END, 1'b1, '{8'h00, 8'h00, TYPE_END, CLASS_END, 1'b1, 1'b1}},
      '{SYNC_RESET, 1'b0, NO_RESULT},   // unknown type, sync as payload, bad checksum
      '{8'h02, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, NO_RESULT},
      '{8'hFF, 1'b1, '{8'hFF, 8'h00, 8'hFF, CLASS_UNKNOWN, 1'b0, 1'b0}},
      '{SYNC_RESET, 1'b1, '{SYNC_RESET, 8'h01, 8'hFF, CLASS_UNKNOWN, 1'b0, 1'b0}},
      '{8'h00, 1'b1, '{8'h00, 8'h00, 8'hFF, CLASS_UNKNOWN, 1'b0, 1'b1}},
      '{SYNC_RESET, 1'b0, NO_RESULT},   // board status with one payload byte
      '{8'h01, 1'b0, NO_RESULT},
      '{TYPE_BOARD, 1'b0, NO_RESULT},
      '{SYNC_RESET, 1'b1, '{SYNC_RESET, 8'h00, TYPE_BOARD, CLASS_BOARD, 1'b0, 1'b0}},
      '{8'h5B, 1'b1, '{8'h00, 8'h00, TYPE_BOARD, CLASS_BOARD, 1'b1, 1'b1}},
      '{SYNC_RESET, 1'b0, NO_RESULT},   // players status, empty
      '{8'h00, 1'b0, NO_RESULT},
      '{TYPE_PLAYERS, 1'b0, NO_RESULT},
      '{TYPE_PLAYERS, 1'b1, '{8'h00, 8'h00, TYPE_PLAYERS, CLASS_PLAYERS, 1'b1, 1'b1}},
      '{SYNC_RESET, 1'b0, NO_RESULT},   // ping, empty
      '{8'h00, 1'b0, NO_RESULT},
      '{TYPE_PING, 1'b0, NO_RESULT},
      '{TYPE_PING, 1'b1, '{8'h00, 8'h00, TYPE_PING, CLASS_PING, 1'b1, 1'b1}}
   };

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [7:0] csr_wdata;

   slcfr_req_if req_ch ();
   slcfr_rsp_if rsp_ch ();

   sync_length_checksum_frame_receiver dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Frame decoder state, mirrored from the receiver's behavior.
   logic [7:0]   rx_sync  = SYNC_RESET;
   rx_phase_type rx_phase = SEEK_SYNC;
   logic [7:0]   rx_left  = 8'h00;
   logic [7:0]   rx_index = 8'h00;
   logic [7:0]   rx_sum   = 8'h00;
   logic [7:0]   rx_type  = 8'h00;

   frame_result_type expected_results [$];

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned error_count   = 0;
   int unsigned bytes_sent    = 0;
   int unsigned payload_items = 0;
   int unsigned frame_ends    = 0;
   int unsigned bad_checksums = 0;
   int unsigned sync_writes   = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic msg_class_type class_for_type(input logic [7:0] frame_type);
      msg_class_type cls;
      cls = CLASS_UNKNOWN;
      if (frame_type == TYPE_END) cls = CLASS_END;
      else if (frame_type == TYPE_BOARD) cls = CLASS_BOARD;
      else if (frame_type == TYPE_PLAYERS) cls = CLASS_PLAYERS;
      else if (frame_type == TYPE_PING) cls = CLASS_PING;
      return cls;
   endfunction

   // Advances the decoder by one received byte; returns 1 when it yields an item.
   function automatic bit decode_rx_byte(input logic [7:0] value,
                                         output frame_result_type res);
      bit produced;
      produced = 1'b0;
      res      = NO_RESULT;
      case (rx_phase)
         SEEK_SYNC: begin
            if (value == rx_sync) rx_phase = TAKE_LENGTH;
         end
         TAKE_LENGTH: begin
            rx_left  = value;
            rx_index = 8'h00;
            rx_phase = TAKE_TYPE;
         end
         TAKE_TYPE: begin
            rx_type  = value;
            rx_sum   = value;
            rx_phase = (rx_left == 8'h00) ? TAKE_CHECKSUM : TAKE_PAYLOAD;
         end
         TAKE_PAYLOAD: begin
            res      = '{value, rx_index, rx_type, class_for_type(rx_type), 1'b0, 1'b0};
            rx_sum   = rx_sum + value;
            rx_index = rx_index + 8'h01;
            rx_left  = rx_left - 8'h01;
            if (rx_left == 8'h00) rx_phase = TAKE_CHECKSUM;
            produced = 1'b1;
         end
         default: begin
            res      = '{8'h00, 8'h00, rx_type, class_for_type(rx_type), rx_sum == value, 1'b1};
            rx_phase = SEEK_SYNC;
            rx_left  = 8'h00;
            rx_index = 8'h00;
            rx_sum   = 8'h00;
            produced = 1'b1;
         end
      endcase
      return produced;
   endfunction

   task automatic note_failure(input string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR at %0t: %s", $time, msg);
   endtask

   task automatic send_byte(input logic [7:0] value, input logic typed,
                            input frame_result_type typed_result);
      frame_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= value;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      bytes_sent++;
      if (decode_rx_byte(value, predicted))
         expected_results.push_back(typed ? typed_result : predicted);
   endtask

   // Mostly well-formed frames with random content, some line noise in between
   // and now and then a frame cut short.
   task automatic send_random_frame();
      logic [7:0]  frame_bytes [$];
      logic [7:0]  length;
      logic [7:0]  ftype;
      logic [7:0]  sum;
      logic [7:0]  value;
      int unsigned pick;
      int unsigned keep;
      repeat (($urandom_range(99) < 70) ? 0 : $urandom_range(1, 4))
         frame_bytes.push_back(8'($urandom_range(255)));
      pick = $urandom_range(99);
      if (pick < 2) length = 8'hFF;
      else if (pick < 4) length = rx_sync;
      else if (pick < 8) length = 8'($urandom_range(9, 254));
      else length = 8'($urandom_range(8));
      case ($urandom_range(5))
         0: ftype = TYPE_END;
         1: ftype = TYPE_BOARD;
         2: ftype = TYPE_PLAYERS;
         3: ftype = TYPE_PING;
         4: ftype = rx_sync;
         default: ftype = 8'($urandom_range(255));
      endcase
      frame_bytes.push_back(rx_sync);
      frame_bytes.push_back(length);
      frame_bytes.push_back(ftype);
      sum = ftype;
      repeat (length) begin
         value = ($urandom_range(9) == 0) ? rx_sync : 8'($urandom_range(255));
         frame_bytes.push_back(value);
         sum = sum + value;
      end
      pick = $urandom_range(99);
      if (pick < 80) frame_bytes.push_back(sum);
      else if (pick < 90) frame_bytes.push_back(sum ^ (8'h01 << $urandom_range(7)));
      else frame_bytes.push_back(8'($urandom_range(255)));
      if ($urandom_range(99) < 6) begin
         keep = $urandom_range(frame_bytes.size() - 1);
         while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
      end
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], 1'b0, NO_RESULT);
   endtask

   // Header and idle bytes leave no item behind, so allow the pipeline to empty too.
   task automatic drain_results();
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_sync(input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      rx_sync = value;
      sync_writes++;
   endtask

   // Result side: random back-pressure and in-order checking.
   initial begin
      frame_result_type got;
      frame_result_type want;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got = '{rsp_ch.data, rsp_ch.index, rsp_ch.raw_type,
                    msg_class_type'(rsp_ch.msg_class), rsp_ch.checksum_ok, rsp_ch.last};
            if (expected_results.size() == 0) begin
               note_failure($sformatf("unexpected item data %h index %h type %h last %b",
                                      got.data, got.index, got.raw_type, got.last));
            end else begin
               want = expected_results.pop_front();
               if (want.last) begin
                  frame_ends++;
                  if (!want.checksum_ok) bad_checksums++;
               end else begin
                  payload_items++;
               end
               if (got !== want)
                  note_failure($sformatf({"data %h/%h index %h/%h type %h/%h class %0d/%0d ",
                                          "ok %b/%b last %b/%b (expected/actual)"},
                                         want.data, got.data, want.index, got.index,
                                         want.raw_type, got.raw_type, want.msg_class,
                                         got.msg_class, want.checksum_ok, got.checksum_ok,
                                         want.last, got.last));
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Ends the run when neither side has moved an item for too long.
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("Timeout: no progress for %0d cycles, %0d items still expected",
               QUIET_LIMIT, expected_results.size());
      $display("Verification failed");
      $finish;
   end

   initial begin
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.rx_byte <= 8'h00;
      csr_we         <= 1'b0;
      csr_wdata      <= 8'h00;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) send_byte(DIRECTED[i].rx_byte, DIRECTED[i].typed, DIRECTED[i].result);
      req_ch.valid <= 1'b0;

      for (int unsigned p = 0; p < NUM_PHASES; p++) begin
         int unsigned target;
         drain_results();
         write_sync((p == 6) ? 8'($urandom_range(255)) : SYNC_PLAN[p]);
         send_idle_pct = SEND_IDLE_PCT[p % 4];
         stall_pct     = STALL_PCT[p % 4];
         target        = bytes_sent + PHASE_ITEMS;
         while (bytes_sent < target) send_random_frame();
         req_ch.valid <= 1'b0;
      end
      drain_results();

      $display("Sent %0d bytes under %0d sync values and four idling mixes;",
               bytes_sent, sync_writes + 1);
      $display("checked %0d payload items and %0d frame ends, %0d of them with a bad checksum.",
               payload_items, frame_ends, bad_checksums);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d failures", error_count);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
